FILE: design/rrdt_pkg.sv
// Shared types, widths and constants for the bank row reuse distance tracker.
`default_nettype none

package rrdt_pkg;

  localparam int unsigned CH_W        = 4;
  localparam int unsigned RK_W        = 3;
  localparam int unsigned BG_W        = 3;
  localparam int unsigned BK_W        = 3;
  localparam int unsigned ROW_W       = 17;
  localparam int unsigned TS_W        = 48;
  localparam int unsigned DIST_W      = 32;
  localparam int unsigned BIN_IDX_W   = 4;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned RPC_W       = 4;
  localparam int unsigned BPR_W       = 6;
  localparam int unsigned BPG_W       = 4;
  localparam int unsigned REF_W       = 16;
  localparam int unsigned SCCD_W      = 7;

  localparam int unsigned MUL_A_W     = 10;
  localparam int unsigned MUL_B_W     = 6;
  localparam int unsigned FLAT_W      = 16;
  localparam int unsigned BIN_W       = 25;
  localparam int unsigned BASE_W      = SCCD_W + 1;

  localparam int unsigned DEF_BANK_SLOTS    = 64;
  localparam int unsigned DEF_HISTORY_DEPTH = 8;

  localparam logic [RPC_W-1:0]     RST_RPC       = 4'd2;
  localparam logic [BPR_W-1:0]     RST_BPR       = 6'd16;
  localparam logic [BPG_W-1:0]     RST_BPG       = 4'd4;
  localparam logic [REF_W-1:0]     RST_REF       = 16'd7800;
  localparam logic [SCCD_W-1:0]    RST_SCCD      = 7'd4;
  localparam logic [REF_W-1:0]     DEFAULT_LIMIT = 16'd10000;
  localparam logic [BASE_W-1:0]    MIN_BASE_BIN  = 8'd8;
  localparam logic [BIN_IDX_W-1:0] MAX_BIN       = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANKS_PER_CHANNEL = 3'd0,
    CFG_BANKS_PER_RANK    = 3'd1,
    CFG_BANKS_PER_GROUP   = 3'd2,
    CFG_REFRESH_INTERVAL  = 3'd3,
    CFG_SHORT_CCD         = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_RB,
    S_MUL_CH,
    S_MUL_RK,
    S_MUL_BG,
    S_CHECK,
    S_META,
    S_RD,
    S_CMP,
    S_DIST,
    S_BIN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [TS_W-1:0]  tstamp;
  } hist_entry_t;

endpackage

`default_nettype wire

FILE: design/rrdt_if.sv
// Valid/ready channel interfaces for access beats and result beats.
`default_nettype none

interface rrdt_in_if;
  import rrdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [RK_W-1:0]  rank;
  logic [BG_W-1:0]  bank_group;
  logic [BK_W-1:0]  bank;
  logic [ROW_W-1:0] row;
  logic [TS_W-1:0]  timestamp;

  modport source (output valid, channel, rank, bank_group, bank, row, timestamp,
                  input ready);
  modport sink (input valid, channel, rank, bank_group, bank, row, timestamp,
                output ready);
endinterface

interface rrdt_out_if;
  import rrdt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [DIST_W-1:0]    hit_distance;
  logic [BIN_IDX_W-1:0] bin_index;
  logic                 overflow;
  logic                 bank_error;

  modport source (output valid, hit, hit_distance, bin_index, overflow, bank_error,
                  input ready);
  modport sink (input valid, hit, hit_distance, bin_index, overflow, bank_error,
                output ready);
endinterface

`default_nettype wire

FILE: design/bank_row_reuse_distance_tracker_top.sv
// Top level of the bank row reuse distance tracker.
//
// One access beat enters on in_if (channel, rank, bank group, bank, row,
// timestamp); one result beat leaves on out_if for every access. The flat
// bank index is built by one shared multiplier in the states S_MUL_RB,
// S_MUL_CH, S_MUL_RK and S_MUL_BG, then the bank's ring of recent rows is
// searched one entry at a time through the single read port of the history
// memory. A hit that does not overflow walks the geometric bins with one
// adder, one bin per cycle. A miss writes its row at the ring head once the
// search ends; a bank error skips the search, an overflow hit the bin walk.
// in_if.ready is high only while the sequencer is idle. A finished result
// sits in the output register while the next access is taken; a stalled
// receiver holds the sequencer at its final step once a second result is
// ready. Reset sets the configuration registers to their default values,
// empties every bank ring at once through per-bank valid bits, and drops
// out_if.valid. Configuration writes on cfg_we_i take effect at the next
// edge and are meant for idle periods only.
`default_nettype none

module bank_row_reuse_distance_tracker_top #(
  parameter int unsigned BANK_SLOTS    = rrdt_pkg::DEF_BANK_SLOTS,
  parameter int unsigned HISTORY_DEPTH = rrdt_pkg::DEF_HISTORY_DEPTH
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [rrdt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [rrdt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  rrdt_in_if.sink                         in_if,
  rrdt_out_if.source                      out_if
);
  import rrdt_pkg::*;

  localparam int unsigned SLOT_W = (BANK_SLOTS > 1) ? $clog2(BANK_SLOTS) : 1;
  localparam int unsigned IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;

  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] count;
  } meta_t;

  // Configuration registers.
  logic [RPC_W-1:0]  rpc_q;
  logic [BPR_W-1:0]  bpr_q;
  logic [BPG_W-1:0]  bpg_q;
  logic [REF_W-1:0]  ref_q;
  logic [SCCD_W-1:0] sccd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpc_q  <= RST_RPC;
      bpr_q  <= RST_BPR;
      bpg_q  <= RST_BPG;
      ref_q  <= RST_REF;
      sccd_q <= RST_SCCD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RANKS_PER_CHANNEL: rpc_q  <= cfg_wdata_i[RPC_W-1:0];
        CFG_BANKS_PER_RANK:    bpr_q  <= cfg_wdata_i[BPR_W-1:0];
        CFG_BANKS_PER_GROUP:   bpg_q  <= cfg_wdata_i[BPG_W-1:0];
        CFG_REFRESH_INTERVAL:  ref_q  <= cfg_wdata_i[REF_W-1:0];
        CFG_SHORT_CCD:         sccd_q <= cfg_wdata_i[SCCD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_e               state_q, state_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic [RK_W-1:0]      rk_q, rk_d;
  logic [BG_W-1:0]      bg_q, bg_d;
  logic [BK_W-1:0]      bk_q, bk_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [TS_W-1:0]      ts_q, ts_d;
  logic [MUL_A_W-1:0]   prod_q, prod_d;
  logic [FLAT_W-1:0]    acc_q, acc_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 hit_q, hit_d;
  logic                 err_q, err_d;
  logic                 ovf_q, ovf_d;
  logic [TS_W-1:0]      dist_q, dist_d;
  logic [BIN_W-1:0]     start_q, start_d;
  logic [BIN_W-1:0]     width_q, width_d;
  logic [BIN_IDX_W-1:0] bin_q, bin_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q, out_hit_d;
  logic [DIST_W-1:0]    out_dist_q, out_dist_d;
  logic [BIN_IDX_W-1:0] out_bin_q, out_bin_d;
  logic                 out_ovf_q, out_ovf_d;
  logic                 out_err_q, out_err_d;

  // Shared multiplier.
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [FLAT_W-1:0]          mul_p;

  assign mul_p = FLAT_W'(mul_a) * FLAT_W'(mul_b);

  always_comb begin
    mul_a = MUL_A_W'(rpc_q);
    mul_b = bpr_q;
    unique case (state_q)
      S_MUL_CH: begin
        mul_a = prod_q;
        mul_b = MUL_B_W'(ch_q);
      end
      S_MUL_RK: begin
        mul_a = MUL_A_W'(bpr_q);
        mul_b = MUL_B_W'(rk_q);
      end
      S_MUL_BG: begin
        mul_a = MUL_A_W'(bpg_q);
        mul_b = MUL_B_W'(bg_q);
      end
      default: ;
    endcase
  end

  // Derived values.
  logic [SLOT_W-1:0]  slot;
  logic               bank_bad;
  logic [REF_W-1:0]   limit;
  logic [BASE_W-1:0]  sccd2;
  logic [BASE_W-1:0]  base;
  logic [BIN_W-1:0]   bin_sum;
  logic [BIN_W-1:0]   dist_lo;
  logic               bin_go;
  logic               dist_ovf;
  logic               search_done;
  logic               row_match;
  logic               out_free;

  assign slot        = acc_q[SLOT_W-1:0];
  assign bank_bad    = acc_q >= FLAT_W'(BANK_SLOTS);
  assign limit       = (ref_q == '0) ? DEFAULT_LIMIT : ref_q;
  assign sccd2       = {sccd_q, 1'b0};
  assign base        = (sccd2 < MIN_BASE_BIN) ? MIN_BASE_BIN : sccd2;
  assign bin_sum     = start_q + width_q;
  assign dist_lo     = BIN_W'(dist_q[REF_W-1:0]);
  assign bin_go      = (dist_lo >= bin_sum) && (bin_q != MAX_BIN);
  assign dist_ovf    = (|dist_q[TS_W-1:REF_W]) || (dist_q[REF_W-1:0] >= limit);
  assign search_done = idx_q >= cnt_q;
  assign out_free    = !out_valid_q || out_if.ready;

  // Ring bookkeeping memory with per-bank valid bits.
  meta_t                meta_mem_q [BANK_SLOTS];
  logic [BANK_SLOTS-1:0] slot_vld_q;
  meta_t                meta_rd_q;
  logic                 meta_vld_rd_q;
  logic                 meta_re;
  logic                 meta_we;
  meta_t                meta_wdata;

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem_q[slot] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd_q     <= meta_mem_q[slot];
      meta_vld_rd_q <= slot_vld_q[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (meta_we) begin
      slot_vld_q[slot] <= 1'b1;
    end
  end

  // Row history memory.
  logic             hist_we;
  logic             hist_re;
  logic [ADDR_W-1:0] hist_waddr;
  logic [ADDR_W-1:0] hist_raddr;
  hist_entry_t      hist_wdata;
  hist_entry_t      hist_rdata;

  rrdt_hist_mem #(
    .ADDR_W (ADDR_W)
  ) u_hist_mem (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  assign row_match = hist_rdata.row == row_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_if.valid) state_d = S_MUL_RB;
      S_MUL_RB: state_d = S_MUL_CH;
      S_MUL_CH: state_d = S_MUL_RK;
      S_MUL_RK: state_d = S_MUL_BG;
      S_MUL_BG: state_d = S_CHECK;
      S_CHECK:  state_d = bank_bad ? S_OUT : S_META;
      S_META:   state_d = S_RD;
      S_RD:     state_d = search_done ? S_OUT : S_CMP;
      S_CMP:    state_d = row_match ? S_DIST : S_RD;
      S_DIST:   state_d = dist_ovf ? S_OUT : S_BIN;
      S_BIN:    if (!bin_go) state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    ch_d    = ch_q;
    rk_d    = rk_q;
    bg_d    = bg_q;
    bk_d    = bk_q;
    row_d   = row_q;
    ts_d    = ts_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    err_d   = err_q;
    ovf_d   = ovf_q;
    dist_d  = dist_q;
    start_d = start_q;
    width_d = width_q;
    bin_d   = bin_q;

    meta_re         = 1'b0;
    meta_we         = 1'b0;
    meta_wdata.head = (head_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
    meta_wdata.count = (cnt_q < CNT_W'(HISTORY_DEPTH)) ? cnt_q + 1'b1 : cnt_q;

    hist_we           = 1'b0;
    hist_re           = 1'b0;
    hist_waddr        = {slot, head_q};
    hist_raddr        = {slot, idx_q[IDX_W-1:0]};
    hist_wdata.row    = row_q;
    hist_wdata.tstamp = ts_q;

    out_valid_d = out_valid_q && !out_if.ready;
    out_hit_d   = out_hit_q;
    out_dist_d  = out_dist_q;
    out_bin_d   = out_bin_q;
    out_ovf_d   = out_ovf_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          ch_d   = in_if.channel;
          rk_d   = in_if.rank;
          bg_d   = in_if.bank_group;
          bk_d   = in_if.bank;
          row_d  = in_if.row;
          ts_d   = in_if.timestamp;
          hit_d  = 1'b0;
          err_d  = 1'b0;
          ovf_d  = 1'b0;
          dist_d = '0;
          bin_d  = '0;
        end
      end
      S_MUL_RB: prod_d = mul_p[MUL_A_W-1:0];
      S_MUL_CH: acc_d = mul_p;
      S_MUL_RK: acc_d = acc_q + mul_p;
      S_MUL_BG: acc_d = acc_q + mul_p + FLAT_W'(bk_q);
      S_CHECK: begin
        if (bank_bad) begin
          err_d = 1'b1;
        end else begin
          meta_re = 1'b1;
        end
      end
      S_META: begin
        head_d = meta_vld_rd_q ? meta_rd_q.head : '0;
        cnt_d  = meta_vld_rd_q ? meta_rd_q.count : '0;
        idx_d  = '0;
      end
      S_RD: begin
        if (search_done) begin
          hist_we = 1'b1;
          meta_we = 1'b1;
        end else begin
          hist_re = 1'b1;
        end
      end
      S_CMP: begin
        if (row_match) begin
          hit_d      = 1'b1;
          dist_d     = ts_q - hist_rdata.tstamp;
          hist_we    = 1'b1;
          hist_waddr = {slot, idx_q[IDX_W-1:0]};
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DIST: begin
        ovf_d   = dist_ovf;
        start_d = '0;
        width_d = BIN_W'(base);
        bin_d   = '0;
      end
      S_BIN: begin
        if (bin_go) begin
          start_d = bin_sum;
          width_d = {width_q[BIN_W-2:0], 1'b0};
          bin_d   = bin_q + 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_dist_d  = (|dist_q[TS_W-1:DIST_W]) ? '1 : dist_q[DIST_W-1:0];
          out_bin_d   = bin_q;
          out_ovf_d   = ovf_q;
          out_err_d   = err_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    rk_q       <= rk_d;
    bg_q       <= bg_d;
    bk_q       <= bk_d;
    row_q      <= row_d;
    ts_q       <= ts_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    head_q     <= head_d;
    cnt_q      <= cnt_d;
    idx_q      <= idx_d;
    hit_q      <= hit_d;
    err_q      <= err_d;
    ovf_q      <= ovf_d;
    dist_q     <= dist_d;
    start_q    <= start_d;
    width_q    <= width_d;
    bin_q      <= bin_d;
    out_hit_q  <= out_hit_d;
    out_dist_q <= out_dist_d;
    out_bin_q  <= out_bin_d;
    out_ovf_q  <= out_ovf_d;
    out_err_q  <= out_err_d;
  end

  assign in_if.ready         = state_q == S_IDLE;
  assign out_if.valid        = out_valid_q;
  assign out_if.hit          = out_hit_q;
  assign out_if.hit_distance = out_dist_q;
  assign out_if.bin_index    = out_bin_q;
  assign out_if.overflow     = out_ovf_q;
  assign out_if.bank_error   = out_err_q;

endmodule

`default_nettype wire

FILE: design/rrdt_hist_mem.sv
// Row history memory: one write port and one registered read port.
`default_nettype none

module rrdt_hist_mem #(
  parameter int unsigned ADDR_W = 9
) (
  input  wire                    clk_i,
  input  wire                    we_i,
  input  wire [ADDR_W-1:0]       waddr_i,
  input  rrdt_pkg::hist_entry_t  wdata_i,
  input  wire                    re_i,
  input  wire [ADDR_W-1:0]       raddr_i,
  output rrdt_pkg::hist_entry_t  rdata_o
);
  import rrdt_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  hist_entry_t mem_q [DEPTH];
  hist_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/rrdt_checker.sv
// Port-level assertions for the tracker and the bind that attaches them.
`default_nettype none

module rrdt_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_ready_i,
  input wire                                out_valid_i,
  input wire                                out_ready_i,
  input wire                                out_hit_i,
  input wire [rrdt_pkg::DIST_W-1:0]         out_hit_distance_i,
  input wire [rrdt_pkg::BIN_IDX_W-1:0]      out_bin_index_i,
  input wire                                out_overflow_i,
  input wire                                out_bank_error_i
);
  import rrdt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hit_i)
      && $stable(out_hit_distance_i) && $stable(out_bin_index_i)
      && $stable(out_overflow_i) && $stable(out_bank_error_i))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("access taken while the previous one is in progress");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bank_error_i |-> !out_hit_i && out_hit_distance_i == '0
      && out_bin_index_i == '0 && !out_overflow_i)
    else $error("bank error result carries other fields");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_hit_i |-> out_hit_distance_i == '0
      && out_bin_index_i == '0 && !out_overflow_i)
    else $error("miss result carries distance fields");

  a_overflow_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_overflow_i |-> out_hit_i && out_bin_index_i == '0)
    else $error("overflow result with a bin index");

endmodule

bind bank_row_reuse_distance_tracker_top rrdt_checker u_rrdt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_if.valid),
  .in_ready_i         (in_if.ready),
  .out_valid_i        (out_if.valid),
  .out_ready_i        (out_if.ready),
  .out_hit_i          (out_if.hit),
  .out_hit_distance_i (out_if.hit_distance),
  .out_bin_index_i    (out_if.bin_index),
  .out_overflow_i     (out_if.overflow),
  .out_bank_error_i   (out_if.bank_error)
);

`default_nettype wire

FILE: bench/bank_row_reuse_distance_tracker_top_tb.sv
// Self-checking testbench for the bank row reuse distance tracker top level.
module bank_row_reuse_distance_tracker_top_tb;
  import rrdt_pkg::*;

  localparam int unsigned BANK_SLOTS    = DEF_BANK_SLOTS;
  localparam int unsigned HISTORY_DEPTH = DEF_HISTORY_DEPTH;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned HOT_BANKS     = 6;
  localparam int unsigned POOL_ROWS     = 12;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned DIRECTED_ROWS = 26;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [RK_W-1:0]  rank;
    logic [BG_W-1:0]  bank_group;
    logic [BK_W-1:0]  bank;
    logic [ROW_W-1:0] row;
    logic [TS_W-1:0]  timestamp;
  } access_t;

  typedef struct packed {
    logic                 hit;
    logic [DIST_W-1:0]    hit_distance;
    logic [BIN_IDX_W-1:0] bin_index;
    logic                 overflow;
    logic                 bank_error;
  } result_t;

  typedef struct packed {
    access_t acc;
    logic    typed;
    result_t res;
  } dir_row_t;

  typedef struct packed {
    logic    typed;
    result_t res;
  } access_note_t;

  typedef struct packed {
    logic [RPC_W-1:0]  rpc;
    logic [BPR_W-1:0]  bpr;
    logic [BPG_W-1:0]  bpg;
    logic [REF_W-1:0]  refi;
    logic [SCCD_W-1:0] sccd;
  } settings_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_idx_e             cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  rrdt_in_if  acc_if ();
  rrdt_out_if res_if ();

  bank_row_reuse_distance_tracker_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (acc_if),
    .out_if      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow configuration and per-bank row history of the tracker.
  logic [RPC_W-1:0]  rpc_q  = RST_RPC;
  logic [BPR_W-1:0]  bpr_q  = RST_BPR;
  logic [BPG_W-1:0]  bpg_q  = RST_BPG;
  logic [REF_W-1:0]  refi_q = RST_REF;
  logic [SCCD_W-1:0] sccd_q = RST_SCCD;

  logic [ROW_W-1:0] recent_rows  [BANK_SLOTS][HISTORY_DEPTH];
  logic [TS_W-1:0]  recent_times [BANK_SLOTS][HISTORY_DEPTH];
  int unsigned      next_slot    [BANK_SLOTS];
  int unsigned      fill_level   [BANK_SLOTS];

  result_t      due_results [$];
  access_note_t access_notes [$];

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_requests = 0;
  int unsigned burst_left;

  access_t          hot_banks [HOT_BANKS];
  logic [ROW_W-1:0] row_pool [POOL_ROWS];
  logic [TS_W-1:0]  now_ts;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{4'd0, 3'd0, 3'd0, 3'd0, 17'h00000, 48'd0}, 1'b1, '{1'b0, 32'd0, 4'd0, 1'b0, 1'b0}},
    '{'{4'd0, 3'd0, 3'd0, 3'd0, 17'h00000, 48'd5}, 1'b1, '{1'b1, 32'd5, 4'd0, 1'b0, 1'b0}},
    '{'{4'd0, 3'd0, 3'd0, 3'd0, 17'h00000, 48'd13}, 1'b1, '{1'b1, 32'd8, 4'd1, 1'b0, 1'b0}},
    '{'{4'd0, 3'd0, 3'd0, 3'd0, 17'h00000, 48'd7813}, 1'b1,
      '{1'b1, 32'd7800, 4'd0, 1'b1, 1'b0}},
    '{'{4'd0, 3'd0, 3'd0, 3'd0, 17'h00000, 48'd15612}, 1'b1,
      '{1'b1, 32'd7799, 4'd9, 1'b0, 1'b0}},
    '{'{4'd15, 3'd7, 3'd7, 3'd7, 17'h1FFFF, 48'hFFFF_FFFF_FFFF}, 1'b1,
      '{1'b0, 32'd0, 4'd0, 1'b0, 1'b1}},
    '{'{4'd2, 3'd0, 3'd0, 3'd0, 17'h01234, 48'd15612}, 1'b1, '{1'b0, 32'd0, 4'd0, 1'b0, 1'b1}},
    '{'{4'd1, 3'd1, 3'd3, 3'd3, 17'h1FFFF, 48'hFFFF_FFFF_FFF0}, 1'b1,
      '{1'b0, 32'd0, 4'd0, 1'b0, 1'b0}},
    '{'{4'd1, 3'd1, 3'd3, 3'd3, 17'h1FFFF, 48'h10}, 1'b1, '{1'b1, 32'd32, 4'd2, 1'b0, 1'b0}},
    '{'{4'd1, 3'd1, 3'd3, 3'd3, 17'h1FFFF, 48'hF}, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b0}},
    '{'{4'd0, 3'd1, 3'd0, 3'd0, 17'h15555, 48'd100}, 1'b1, '{1'b0, 32'd0, 4'd0, 1'b0, 1'b0}},
    '{'{4'd0, 3'd0, 3'd0, 3'd4, 17'h0AAAA, 48'd200}, 1'b1, '{1'b0, 32'd0, 4'd0, 1'b0, 1'b0}},
    '{'{4'd0, 3'd0, 3'd1, 3'd0, 17'h0AAAA, 48'd210}, 1'b1, '{1'b1, 32'd10, 4'd1, 1'b0, 1'b0}},
    '{'{4'd0, 3'd1, 3'd0, 3'd0, 17'h15555, 48'h1_0000_0064}, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b0}},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00100, 48'd1000}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00101, 48'd1001}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00102, 48'd1002}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00103, 48'd1003}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00104, 48'd1004}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00105, 48'd1005}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00106, 48'd1006}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00107, 48'd1007}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00108, 48'd1008}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00100, 48'd1010}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00108, 48'd1020}, 1'b0, '0},
    '{'{4'd0, 3'd0, 3'd0, 3'd2, 17'h00102, 48'd1030}, 1'b0, '0}
  };

  settings_t phase_settings [PHASES] = '{
    '{RST_RPC, RST_BPR, RST_BPG, RST_REF, RST_SCCD},
    '{4'd8, 6'd32, 4'd8, 16'd65535, 7'd64},
    '{4'd1, 6'd1, 4'd1, 16'd0, 7'd1},
    '{4'd0, 6'd0, 4'd15, 16'd1, 7'd0},
    '{4'd15, 6'd63, 4'd0, 16'd300, 7'd127},
    '{4'd1, 6'd4, 4'd2, 16'd2000, 7'd10}
  };

  function automatic logic [31:0] flat_bank(input access_t a);
    return 32'(a.channel) * (32'(rpc_q) * 32'(bpr_q)) + 32'(a.rank) * 32'(bpr_q)
         + 32'(a.bank_group) * 32'(bpg_q) + 32'(a.bank);
  endfunction

  function automatic logic [BIN_IDX_W-1:0] distance_bin(input logic [TS_W-1:0] gap);
    logic [TS_W-1:0]      lo;
    logic [TS_W-1:0]      span;
    logic [BIN_IDX_W-1:0] idx;
    span = TS_W'({sccd_q, 1'b0});
    if (span < TS_W'(MIN_BASE_BIN)) span = TS_W'(MIN_BASE_BIN);
    lo = '0;
    idx = '0;
    while (gap >= lo + span && idx < MAX_BIN) begin
      lo = lo + span;
      span = span << 1;
      idx = idx + 1'b1;
    end
    return idx;
  endfunction

  function automatic result_t track_reuse(input access_t a);
    result_t         r;
    logic [31:0]     slot;
    logic [TS_W-1:0] gap;
    logic [TS_W-1:0] lim;
    int unsigned     fill;
    int unsigned     head;
    bit              found;
    r = '0;
    found = 1'b0;
    slot = flat_bank(a);
    if (slot >= BANK_SLOTS) begin
      r.bank_error = 1'b1;
      return r;
    end
    lim = (refi_q != '0) ? TS_W'(refi_q) : TS_W'(DEFAULT_LIMIT);
    fill = fill_level[slot];
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (!found && i < fill && recent_rows[slot][i] == a.row) begin
        found = 1'b1;
        gap = a.timestamp - recent_times[slot][i];
        r.hit = 1'b1;
        r.hit_distance = (gap > TS_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : gap[DIST_W-1:0];
        if (gap >= lim) begin
          r.overflow = 1'b1;
        end else begin
          r.bin_index = distance_bin(gap);
        end
        recent_times[slot][i] = a.timestamp;
      end
    end
    if (!found) begin
      head = next_slot[slot];
      recent_rows[slot][head] = a.row;
      recent_times[slot][head] = a.timestamp;
      next_slot[slot] = (head + 1) % HISTORY_DEPTH;
      if (fill < HISTORY_DEPTH) fill_level[slot] = fill + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DIST_W-1:0] got,
                                 input logic [DIST_W-1:0] want);
    if (mismatches < 100) begin
      $display("tb: %s mismatch at cycle %0d: got %0h, want %0h", what, cycles, got, want);
    end
    mismatches++;
  endtask

  // Result beats are checked before the access accepted at the same edge is predicted.
  always @(posedge clk_i) begin
    result_t      got;
    result_t      want;
    access_note_t note;
    result_t      pred;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.hit, res_if.hit_distance, res_if.bin_index, res_if.overflow,
                res_if.bank_error};
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", got.hit_distance, '0);
        end else begin
          want = due_results.pop_front();
          if (got.hit !== want.hit) begin
            report_mismatch("hit", DIST_W'(got.hit), DIST_W'(want.hit));
          end
          if (got.hit_distance !== want.hit_distance) begin
            report_mismatch("hit_distance", got.hit_distance, want.hit_distance);
          end
          if (got.bin_index !== want.bin_index) begin
            report_mismatch("bin_index", DIST_W'(got.bin_index), DIST_W'(want.bin_index));
          end
          if (got.overflow !== want.overflow) begin
            report_mismatch("overflow", DIST_W'(got.overflow), DIST_W'(want.overflow));
          end
          if (got.bank_error !== want.bank_error) begin
            report_mismatch("bank_error", DIST_W'(got.bank_error), DIST_W'(want.bank_error));
          end
        end
      end
      if (acc_if.valid && acc_if.ready) begin
        pred = track_reuse('{acc_if.channel, acc_if.rank, acc_if.bank_group, acc_if.bank,
                             acc_if.row, acc_if.timestamp});
        note = access_notes.pop_front();
        due_results.insert(due_results.size(), note.typed ? note.res : pred);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    logic [31:0] tick;
    logic        rdy;
    hold_seen = 0;
    hold_left = 0;
    tick = '0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick = tick + 1;
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (tick[9:7])
          3'd3: rdy = 1'($urandom_range(0, 1));
          3'd4: rdy = (tick[1:0] == 2'd0);
          3'd5: rdy = ($urandom_range(0, 7) == 0);
          3'd6: rdy = (tick[4:0] >= 5'd10);
          3'd7: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = 1'b1;
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  task automatic send_access(input access_t a, input logic typed, input result_t res);
    access_notes.insert(access_notes.size(), access_note_t'{typed, res});
    acc_if.valid      <= 1'b1;
    acc_if.channel    <= a.channel;
    acc_if.rank       <= a.rank;
    acc_if.bank_group <= a.bank_group;
    acc_if.bank       <= a.bank;
    acc_if.row        <= a.row;
    acc_if.timestamp  <= a.timestamp;
    @(posedge clk_i);
    while (!acc_if.ready) @(posedge clk_i);
  endtask

  task automatic pace_sender();
    burst_left--;
    if (burst_left == 0) begin
      acc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_for_results();
    acc_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0 || !acc_if.ready);
  endtask

  task automatic apply_settings(input settings_t s);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_RANKS_PER_CHANNEL;
    cfg_wdata_i <= CFG_DATA_W'(s.rpc);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BANKS_PER_RANK;
    cfg_wdata_i <= CFG_DATA_W'(s.bpr);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BANKS_PER_GROUP;
    cfg_wdata_i <= CFG_DATA_W'(s.bpg);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_REFRESH_INTERVAL;
    cfg_wdata_i <= CFG_DATA_W'(s.refi);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SHORT_CCD;
    cfg_wdata_i <= CFG_DATA_W'(s.sccd);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rpc_q  = s.rpc;
    bpr_q  = s.bpr;
    bpg_q  = s.bpg;
    refi_q = s.refi;
    sccd_q = s.sccd;
  endtask

  function automatic access_t random_bank();
    access_t a;
    a = '0;
    a.channel    = CH_W'($urandom);
    a.rank       = RK_W'($urandom);
    a.bank_group = BG_W'($urandom);
    a.bank       = BK_W'($urandom);
    return a;
  endfunction

  // Hot banks are valid under the current settings so that rows get reused.
  task automatic choose_hot_banks();
    access_t     a;
    int unsigned tries;
    foreach (hot_banks[h]) begin
      tries = 0;
      do begin
        a = random_bank();
        tries++;
      end while (flat_bank(a) >= BANK_SLOTS && tries < 2000);
      if (flat_bank(a) >= BANK_SLOTS) a = '0;
      hot_banks[h] = a;
    end
    foreach (row_pool[r]) row_pool[r] = ROW_W'($urandom);
    now_ts = TS_W'({$urandom, $urandom});
  endtask

  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    int unsigned step;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      a = hot_banks[$urandom_range(0, HOT_BANKS - 1)];
      a.row = (pick < 70) ? row_pool[$urandom_range(0, POOL_ROWS - 1)] : ROW_W'($urandom);
    end else begin
      a = random_bank();
      a.row = ROW_W'($urandom);
    end
    step = $urandom_range(0, 99);
    if (step < 70) begin
      now_ts = now_ts + TS_W'($urandom_range(0, 40));
    end else if (step < 90) begin
      now_ts = now_ts + TS_W'($urandom_range(0, 3000));
    end else if (step < 96) begin
      now_ts = now_ts + TS_W'($urandom_range(0, 70000));
    end else if (step < 98) begin
      now_ts = TS_W'({$urandom, $urandom});
    end else begin
      now_ts = now_ts + TS_W'({$urandom, $urandom});
    end
    a.timestamp = now_ts;
    return a;
  endfunction

  task automatic run_random(input int unsigned count, input bit with_hold);
    for (int unsigned k = 0; k < count; k++) begin
      if (with_hold && k == count / 3) hold_requests <= hold_requests + 1;
      send_access(random_access(), 1'b0, '0);
      pace_sender();
    end
  endtask

  initial begin
    foreach (next_slot[s]) begin
      next_slot[s] = 0;
      fill_level[s] = 0;
    end
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_RANKS_PER_CHANNEL;
    cfg_wdata_i       <= '0;
    acc_if.valid      <= 1'b0;
    acc_if.channel    <= '0;
    acc_if.rank       <= '0;
    acc_if.bank_group <= '0;
    acc_if.bank       <= '0;
    acc_if.row        <= '0;
    acc_if.timestamp  <= '0;
    burst_left = $urandom_range(1, 24);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_rows[k]) begin
      send_access(directed_rows[k].acc, directed_rows[k].typed, directed_rows[k].res);
      pace_sender();
    end
    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_for_results();
        apply_settings(phase_settings[p]);
      end
      choose_hot_banks();
      run_random((p == 0) ? 150 : 120, p == 0);
    end
    wait_for_results();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rrdt_pkg.sv
design/rrdt_if.sv
design/rrdt_hist_mem.sv
design/bank_row_reuse_distance_tracker_top.sv
design/rrdt_checker.sv
bench/bank_row_reuse_distance_tracker_top_tb.sv
